// File: sv/qdd_pkg.sv
package qdd_pkg;

  localparam int unsigned NumEncodersDefault = 4;
  localparam int unsigned EncIdxW = 3;
  localparam int unsigned PosW = 32;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // register index in the configuration map
  localparam logic [0:0] RegFilterEn = 1'b0;

  // pin pair codes, {clk, dt}
  localparam logic [1:0] Pins00 = 2'b00;
  localparam logic [1:0] Pins01 = 2'b01;
  localparam logic [1:0] Pins10 = 2'b10;
  localparam logic [1:0] Pins11 = 2'b11;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_CW   = 2'd1,
    EV_CCW  = 2'd2
  } qdd_event_e;

  typedef enum logic [6:0] {
    ST_REST = 7'b0000001,
    ST_CW1  = 7'b0000010,
    ST_CW2  = 7'b0000100,
    ST_CW3  = 7'b0001000,
    ST_CCW1 = 7'b0010000,
    ST_CCW2 = 7'b0100000,
    ST_CCW3 = 7'b1000000
  } qdd_state_e;

  typedef struct packed {
    logic               kind;
    logic [EncIdxW-1:0] encoder_index;
    logic               clk_level;
    logic               dt_level;
  } qdd_item_t;

  typedef struct packed {
    qdd_event_e             event_out;
    logic signed [PosW-1:0] position_out;
    logic                   index_valid;
  } qdd_result_t;

  // full Gray cycle transition table
  function automatic qdd_state_e qdd_next_state(qdd_state_e st, logic [1:0] pins);
    qdd_state_e nst;
    nst = ST_REST;
    case (st)
      ST_CW1: begin
        nst = (pins == Pins00) ? ST_CW2 : (pins == Pins01) ? ST_CW1 : ST_REST;
      end
      ST_CW2: begin
        nst = (pins == Pins00) ? ST_CW2 : (pins == Pins01) ? ST_CW1 :
              (pins == Pins10) ? ST_CW3 : ST_REST;
      end
      ST_CW3: begin
        nst = (pins == Pins00) ? ST_CW2 : (pins == Pins10) ? ST_CW3 : ST_REST;
      end
      ST_CCW1: begin
        nst = (pins == Pins00) ? ST_CCW2 : (pins == Pins10) ? ST_CCW1 : ST_REST;
      end
      ST_CCW2: begin
        nst = (pins == Pins00) ? ST_CCW2 : (pins == Pins01) ? ST_CCW3 :
              (pins == Pins10) ? ST_CCW1 : ST_REST;
      end
      ST_CCW3: begin
        nst = (pins == Pins00) ? ST_CCW2 : (pins == Pins01) ? ST_CCW3 : ST_REST;
      end
      default: begin
        // rest, and any stray code acts as rest
        nst = (pins == Pins01) ? ST_CW1 : (pins == Pins10) ? ST_CCW1 : ST_REST;
      end
    endcase
    return nst;
  endfunction

endpackage

// File: sv/qdd_apb_regs.sv
module qdd_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qdd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [qdd_pkg::ApbDataW-1:0]  pwdata,
  output logic [qdd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output logic                          filter_en_o
);
  import qdd_pkg::*;

  logic       filter_en_q, filter_en_d;
  logic [0:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ApbAddrW-1 -: 1];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    filter_en_d = filter_en_q;
    if (wr_en && (reg_idx == RegFilterEn)) begin
      filter_en_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b1;
    end else begin
      filter_en_q <= filter_en_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == RegFilterEn) begin
      prdata = {{(ApbDataW-1){1'b0}}, filter_en_q};
    end
  end

  assign filter_en_o = filter_en_q;

endmodule

// File: sv/qdd_enc_bank.sv
module qdd_enc_bank #(
  parameter int unsigned NUM_ENCODERS = qdd_pkg::NumEncodersDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qdd_pkg::qdd_item_t   item_i,
  input  logic                 commit_i,
  input  logic                 filter_en_i,
  output qdd_pkg::qdd_result_t result_o
);
  import qdd_pkg::*;

  localparam int unsigned IdxW = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;

  qdd_state_e             state_q     [NUM_ENCODERS];
  logic signed [PosW-1:0] pos_q       [NUM_ENCODERS];
  logic [CountW-1:0]      cw_cnt_q    [NUM_ENCODERS];
  logic [CountW-1:0]      ccw_cnt_q   [NUM_ENCODERS];
  logic                   last_vld_q  [NUM_ENCODERS];
  logic [1:0]             last_pins_q [NUM_ENCODERS];

  qdd_state_e             state_d;
  logic signed [PosW-1:0] pos_d;
  logic [CountW-1:0]      cw_cnt_d, ccw_cnt_d;
  logic                   last_vld_d;
  logic [1:0]             last_pins_d;

  logic            in_range;
  logic [IdxW-1:0] sel;
  logic [1:0]      pins;
  logic            drop;
  qdd_event_e      ev;

  assign in_range = ({1'b0, item_i.encoder_index} < (EncIdxW+1)'(NUM_ENCODERS));
  assign sel      = item_i.encoder_index[IdxW-1:0];
  assign pins     = {item_i.clk_level, item_i.dt_level};
  assign drop     = filter_en_i && last_vld_q[sel] && (pins == last_pins_q[sel]);

  always_comb begin
    state_d     = state_q[sel];
    pos_d       = pos_q[sel];
    cw_cnt_d    = cw_cnt_q[sel];
    ccw_cnt_d   = ccw_cnt_q[sel];
    last_vld_d  = last_vld_q[sel];
    last_pins_d = last_pins_q[sel];
    ev          = EV_NONE;
    if (!item_i.kind) begin
      if (!drop) begin
        last_vld_d  = 1'b1;
        last_pins_d = pins;
        state_d     = qdd_next_state(state_q[sel], pins);
        if (pins == Pins11 && state_q[sel] == ST_CW3) begin
          ev    = EV_CW;
          pos_d = pos_q[sel] + PosW'(1);
          if (cw_cnt_q[sel] != CountMax) begin
            cw_cnt_d = cw_cnt_q[sel] + CountW'(1);
          end
        end else if (pins == Pins11 && state_q[sel] == ST_CCW3) begin
          ev    = EV_CCW;
          pos_d = pos_q[sel] - PosW'(1);
          if (ccw_cnt_q[sel] != CountMax) begin
            ccw_cnt_d = ccw_cnt_q[sel] + CountW'(1);
          end
        end
      end
    end else begin
      // pop one pending event, clockwise first
      if (cw_cnt_q[sel] != '0) begin
        ev       = EV_CW;
        cw_cnt_d = cw_cnt_q[sel] - CountW'(1);
      end else if (ccw_cnt_q[sel] != '0) begin
        ev        = EV_CCW;
        ccw_cnt_d = ccw_cnt_q[sel] - CountW'(1);
      end
    end
  end

  always_comb begin
    result_o.event_out    = EV_NONE;
    result_o.position_out = '0;
    result_o.index_valid  = 1'b0;
    if (in_range) begin
      result_o.event_out    = ev;
      result_o.position_out = pos_d;
      result_o.index_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        state_q[i]     <= ST_REST;
        pos_q[i]       <= '0;
        cw_cnt_q[i]    <= '0;
        ccw_cnt_q[i]   <= '0;
        last_vld_q[i]  <= 1'b0;
        last_pins_q[i] <= Pins00;
      end
    end else begin
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        if (commit_i && in_range && (sel == IdxW'(i))) begin
          state_q[i]     <= state_d;
          pos_q[i]       <= pos_d;
          cw_cnt_q[i]    <= cw_cnt_d;
          ccw_cnt_q[i]   <= ccw_cnt_d;
          last_vld_q[i]  <= last_vld_d;
          last_pins_q[i] <= last_pins_d;
        end
      end
    end
  end

endmodule

// File: sv/quadrature_detent_decoder_top.sv
// Quadrature detent decoder for up to eight two-pin rotary encoders. Each
// transaction either feeds one {clk, dt} pin sample to an encoder or pops one
// pending detent event (clockwise first) from it, and yields exactly one result
// transaction: the event, the encoder's position after the item and an index
// valid flag (indexes at or above NUM_ENCODERS change nothing and return zeros).
// A detent counts only after the full Gray cycle is seen; a bounce steps
// back one state and double jumps fall back to rest silently. Positions wrap at
// 32 bits, pending counts saturate at 65535. The repeat filter (register 0, reset
// 1) drops a sample equal to the last one fed to that encoder. Timing: one
// transaction per clock unless the result channel stalls; each item passes the
// input register, then the per-encoder state update into the result register.
// The next item sees the previous item's update, so back-to-back items on one
// encoder are exact. Configuration writes only while the block is idle.
module quadrature_detent_decoder_top #(
  parameter int unsigned NUM_ENCODERS = qdd_pkg::NumEncodersDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qdd_pkg::ApbAddrW-1:0]       paddr,
  input  logic [qdd_pkg::ApbDataW-1:0]       pwdata,
  output logic [qdd_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [qdd_pkg::EncIdxW-1:0]        encoder_index_i,
  input  logic                               clk_level_i,
  input  logic                               dt_level_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         event_out_o,
  output logic signed [qdd_pkg::PosW-1:0]    position_out_o,
  output logic                               index_valid_o
);
  import qdd_pkg::*;

  logic        filter_en;
  logic        s1_valid_q, s1_valid_d;
  qdd_item_t   item_q;
  logic        out_valid_q, out_valid_d;
  qdd_result_t result_q;
  qdd_result_t result_d;
  logic        out_ready;
  logic        commit;

  qdd_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .filter_en_o (filter_en)
  );

  // result register is free, or its transaction leaves this cycle
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign commit     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.kind          <= kind_i;
      item_q.encoder_index <= encoder_index_i;
      item_q.clk_level     <= clk_level_i;
      item_q.dt_level      <= dt_level_i;
    end
    if (commit) begin
      result_q <= result_d;
    end
  end

  // state is written at the same edge the result is captured
  qdd_enc_bank #(
    .NUM_ENCODERS (NUM_ENCODERS)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_q),
    .commit_i    (commit),
    .filter_en_i (filter_en),
    .result_o    (result_d)
  );

  assign out_valid_o    = out_valid_q;
  assign event_out_o    = result_q.event_out;
  assign position_out_o = result_q.position_out;
  assign index_valid_o  = result_q.index_valid;

endmodule
